// File: rtl/pee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and character codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    // ASCII codes of the characters the evaluator acts on
    localparam logic [7:0] SYM_ZERO  = 8'd48;
    localparam logic [7:0] SYM_NINE  = 8'd57;
    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_SLASH = 8'd47;
    localparam logic [7:0] SYM_TIMES = 8'd120;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

endpackage

// File: rtl/pee_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_alu
// Iterative 32-bit arithmetic unit built around one shared 34-bit adder.
// Add and subtract take one step, multiply 32 shift-add steps, divide
// 32 restoring steps plus sign handling around them.
// ----------------------------------------------------------------------------
module pee_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  pee_pkg::alu_req_t req,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output pee_pkg::alu_rsp_t rsp
);
    import pee_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ABSA,
        A_ABSB,
        A_STEP,
        A_FIX
    } alu_state_t;

    alu_state_t  state_reg;
    alu_op_t     op_reg;
    logic [31:0] acc_reg;   // partial product high half, or remainder
    logic [31:0] q_reg;     // multiplier / dividend / quotient
    logic [31:0] d_reg;     // multiplicand / divisor
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [31:0] result_reg;

    // shared adder
    logic [33:0] add_x;
    logic [33:0] add_y;
    logic        add_sub;
    logic [33:0] add_sum;

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            A_ABSA:
            begin
                add_y   = {2'b00, q_reg};
                add_sub = 1'b1;
            end
            A_ABSB:
            begin
                add_y   = {2'b00, d_reg};
                add_sub = 1'b1;
            end
            A_FIX:
            begin
                add_y   = {2'b00, q_reg};
                add_sub = 1'b1;
            end
            A_STEP:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        add_x = {2'b00, q_reg};
                        add_y = {2'b00, d_reg};
                    end
                    OP_SUB:
                    begin
                        add_x   = {2'b00, q_reg};
                        add_y   = {2'b00, d_reg};
                        add_sub = 1'b1;
                    end
                    OP_MUL:
                    begin
                        add_x = {2'b00, acc_reg};
                        add_y = q_reg[0] ? {2'b00, d_reg} : '0;
                    end
                    OP_DIV:
                    begin
                        add_x   = {1'b0, acc_reg, q_reg[31]};
                        add_y   = {2'b00, d_reg};
                        add_sub = 1'b1;
                    end
                    default:
                    begin
                        add_x = '0;
                    end
                endcase
            end
            default:
            begin
                add_x = '0;
            end
        endcase
    end

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};

    // restoring divide step: a negative trial keeps the shifted remainder
    logic [31:0] div_rem;
    logic [31:0] div_q;
    assign div_rem = add_sum[33] ? {acc_reg[30:0], q_reg[31]} : add_sum[31:0];
    assign div_q   = {q_reg[30:0], ~add_sum[33]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    // done is raised only on the way back here, so drop it now
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        q_reg   <= a;
                        d_reg   <= b;
                        acc_reg <= '0;
                        cnt_reg <= 5'd31;
                        neg_reg <= a[31] ^ b[31];
                        state_reg <= (req.op == OP_DIV) ? A_ABSA : A_STEP;
                    end
                end
                A_ABSA:
                begin
                    if (q_reg[31])
                    begin
                        q_reg <= add_sum[31:0];
                    end
                    state_reg <= A_ABSB;
                end
                A_ABSB:
                begin
                    if (d_reg[31])
                    begin
                        d_reg <= add_sum[31:0];
                    end
                    state_reg <= A_STEP;
                end
                A_STEP:
                begin
                    unique case (op_reg)
                        OP_ADD, OP_SUB:
                        begin
                            result_reg <= add_sum[31:0];
                            done_reg   <= 1'b1;
                            state_reg  <= A_IDLE;
                        end
                        OP_MUL:
                        begin
                            acc_reg <= add_sum[32:1];
                            q_reg   <= {add_sum[0], q_reg[31:1]};
                            cnt_reg <= cnt_reg - 5'd1;
                            if (cnt_reg == 5'd0)
                            begin
                                result_reg <= {add_sum[0], q_reg[31:1]};
                                done_reg   <= 1'b1;
                                state_reg  <= A_IDLE;
                            end
                        end
                        OP_DIV:
                        begin
                            acc_reg <= div_rem;
                            q_reg   <= div_q;
                            cnt_reg <= cnt_reg - 5'd1;
                            if (cnt_reg == 5'd0)
                            begin
                                if (neg_reg)
                                begin
                                    state_reg <= A_FIX;
                                end
                                else
                                begin
                                    result_reg <= div_q;
                                    done_reg   <= 1'b1;
                                    state_reg  <= A_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= A_IDLE;
                        end
                    endcase
                end
                A_FIX:
                begin
                    result_reg <= add_sum[31:0];
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// File: rtl/postfix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Reverse Polish evaluator fed one ASCII character per transaction. Digits
// push, + - x / pop two values and push the result, errors are sticky.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ----------------------------------
//  item      item_valid / item_stall    symbol[7:0], first
//  result    result_valid / result_stall top_value[31:0], depth[7:0],
//                                       status[1:0]
//
//  Sequence: a digit, an ignored character or an error goes straight to
//  the report state; an operator first reads the second entry, where a
//  zero divisor is reported, and otherwise runs on the shared adder in
//  pee_alu. The next transaction is taken in the cycle after the result
//  is loaded.
//  Reset: clears the stack count, error code, state and result_valid; stack
//  memory contents stay undefined and are never used before written.
//  Stalls: one item is in flight at a time; item_stall stays high until
//  the result is placed in the output register, and a stalled result holds.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  symbol,
    input  logic        first,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] top_value,
    output logic [7:0]  depth,
    output logic [1:0]  status
);
    import pee_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);   // count holds 0..STACK_DEPTH
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_REPORT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    status_t         err_reg;
    logic [31:0]     tos_reg;        // top of stack lives in a register
    alu_op_t         op_reg;
    logic            result_valid_reg;
    logic [31:0]     top_value_reg;
    logic [7:0]      depth_reg;
    logic [1:0]      status_reg;

    // Stack below the top entry; entry i holds stack element i.
    logic [31:0]     stack_mem [STACK_DEPTH];
    logic [31:0]     rd_data_reg;

    // ------------------------------------------------------------------
    // Decode at accept: a set first bit empties the stack and clears the error before use.
    // ------------------------------------------------------------------
    logic            accept;
    logic [CW-1:0]   count_eff;
    status_t         err_eff;
    logic            is_digit;
    logic            is_op;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m2;
    logic            push_ok;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    alu_op_t         op_dec;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    assign count_eff = first ? '0 : count_reg;
    assign err_eff   = first ? ST_OK : err_reg;
    assign is_digit  = (symbol >= SYM_ZERO) && (symbol <= SYM_NINE);
    assign is_op     = (symbol == SYM_PLUS) || (symbol == SYM_MINUS)
                    || (symbol == SYM_SLASH) || (symbol == SYM_TIMES);
    assign cnt_m1    = count_eff - CW'(1);
    assign cnt_m2    = count_eff - CW'(2);
    assign wr_addr   = cnt_m1[AW-1:0];
    assign rd_addr   = cnt_m2[AW-1:0];
    assign push_ok   = (count_eff < CW'(STACK_DEPTH));

    // Push spills the old top into memory, unless the stack was empty
    assign mem_we = accept && (err_eff == ST_OK) && is_digit && push_ok
                 && (count_eff != '0);

    always_comb
    begin
        priority if (symbol == SYM_PLUS)
        begin
            op_dec = OP_ADD;
        end
        else if (symbol == SYM_MINUS)
        begin
            op_dec = OP_SUB;
        end
        else if (symbol == SYM_TIMES)
        begin
            op_dec = OP_MUL;
        end
        else
        begin
            op_dec = OP_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Shared arithmetic unit: A is the second entry, B the top entry.
    // ------------------------------------------------------------------
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     div_zero;

    assign div_zero      = (op_reg == OP_DIV) && (tos_reg == '0);
    assign alu_req.start = (state_reg == S_READ) && !div_zero;
    assign alu_req.op    = op_reg;

    pee_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rd_data_reg),
        .b     (tos_reg),
        .rsp   (alu_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            err_reg          <= ST_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once taken; a reload in S_REPORT takes its place
            if (result_valid_reg && !result_stall && (state_reg != S_REPORT))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= op_dec;
                        priority if ((err_eff == ST_OK) && is_digit && push_ok)
                        begin
                            tos_reg   <= 32'(symbol - SYM_ZERO);
                            count_reg <= count_eff + CW'(1);
                            err_reg   <= err_eff;
                            state_reg <= S_REPORT;
                        end
                        else if ((err_eff == ST_OK) && is_digit)
                        begin
                            count_reg <= count_eff;
                            err_reg   <= ST_OVER;
                            state_reg <= S_REPORT;
                        end
                        else if ((err_eff == ST_OK) && is_op && (count_eff < CW'(2)))
                        begin
                            count_reg <= count_eff;
                            err_reg   <= ST_UNDER;
                            state_reg <= S_REPORT;
                        end
                        else if ((err_eff == ST_OK) && is_op)
                        begin
                            count_reg <= count_eff;
                            err_reg   <= err_eff;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            // ignored character or held error: leave the stack
                            count_reg <= count_eff;
                            err_reg   <= err_eff;
                            state_reg <= S_REPORT;
                        end
                    end
                end
                S_READ:
                begin
                    // second entry is now in rd_data_reg
                    if (div_zero)
                    begin
                        err_reg   <= ST_DIVZERO;
                        state_reg <= S_REPORT;
                    end
                    else
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    if (alu_rsp.done)
                    begin
                        tos_reg   <= alu_rsp.result;
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_REPORT;
                    end
                end
                S_REPORT:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        top_value_reg    <= (count_reg != '0) ? tos_reg : '0;
                        depth_reg        <= 8'(count_reg);
                        status_reg       <= err_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign top_value    = top_value_reg;
    assign depth        = depth_reg;
    assign status       = status_reg;

endmodule
